// ===== rtl/tsp_pkg.sv =====
// Package for the tacho speed PID drive unit.
// Holds widths, register indexes, reset values, sequencer states and the 8-bit saturation helper.
// No dependencies.
package tsp_pkg;

  localparam int FRACTION_BITS_DEF = 8;
  localparam int SUM_WIDTH_DEF     = 40;

  localparam int GAIN_FRAC = 8;
  localparam int SPEED_W   = 24;
  localparam int TOTAL_W   = 42;
  localparam int MUL_A_W   = 32;
  localparam int MUL_B_W   = 26;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int SPD_PW    = 48;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET,
    REG_KP,
    REG_KI,
    REG_KD,
    REG_SCALE,
    REG_PERIOD,
    REG_DRIVE_MAX
  } reg_index_t;

  localparam logic [22:0] TARGET_RST    = 23'd2304;
  localparam logic [15:0] KP_RST        = 16'd2560;
  localparam logic [15:0] KI_RST        = 16'd384;
  localparam logic [15:0] KD_RST        = 16'd192;
  localparam logic [15:0] SCALE_RST     = 16'd12776;
  localparam logic [9:0]  PERIOD_RST    = 10'd50;
  localparam logic [6:0]  DRIVE_MAX_RST = 7'd80;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SPD_MUL,
    S_SPD_LD,
    S_SPD_DIV,
    S_ERR,
    S_KP_MUL,
    S_KI_MUL,
    S_KD_MUL,
    S_SUM_LO,
    S_SUM_HI,
    S_D_LD,
    S_D_DIV,
    S_FIN
  } state_t;

  function automatic logic signed [7:0] sat8(logic big, logic [6:0] low, logic neg);
    logic signed [7:0] r;
    if (neg) begin
      r = big ? -8'sd128 : -$signed({1'b0, low});
    end else begin
      r = (big || (&low)) ? 8'sd127 : $signed({1'b0, low});
    end
    return r;
  endfunction

endpackage

// ===== rtl/tsp_mul.sv =====
// Shared unsigned multiplier with a registered product.
// Depends on tsp_pkg for operand widths.
module tsp_mul import tsp_pkg::*; (
  input  logic               clk,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic [MUL_P_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule

// ===== rtl/tsp_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on tsp_pkg for the divisor width.
module tsp_div import tsp_pkg::*; #(
  parameter int NW = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [NW-1:0]      num,
  input  logic [MUL_A_W-1:0] den,
  output logic               done,
  output logic [NW-1:0]      quot
);

  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0]      cnt;
  logic [MUL_A_W-1:0] den_r;
  logic [MUL_A_W:0]   rem;
  logic [MUL_A_W:0]   rem_sh;
  logic               fit;

  always_comb begin
    rem_sh = {rem[MUL_A_W-1:0], quot[NW-1]};
    fit    = rem_sh >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CW'(NW);
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        done <= (cnt == CW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot  <= num;
      rem   <= '0;
      den_r <= den;
    end else if (cnt != '0) begin
      rem  <= fit ? rem_sh - {1'b0, den_r} : rem_sh;
      quot <= {quot[NW-2:0], fit};
    end
  end

endmodule

// ===== rtl/tacho_speed_pid_drive_unit.sv =====
// A regular request runs the bit-serial divider, NW = 48 + max(FRACTION_BITS-8, 0) bits wide,
// twice (speed, then D term) and one shared multiplier; a seed request (the first, or a zero time
// delta) goes straight to the final step. Next request is taken the cycle after the result is
// registered. A result held by result_stall keeps the unit in its final step and stalls new
// requests. Synchronous reset restores register defaults and clears all loop state.
module tacho_speed_pid_drive_unit import tsp_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int SUM_WIDTH     = SUM_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  output logic                    item_stall,
  input  logic [31:0]             tacho_count,
  input  logic [31:0]             time_ms,
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic [6:0]              drive_level,
  output logic signed [SPEED_W-1:0] measured_speed,
  output logic signed [SPEED_W-1:0] speed_error,
  output logic                    speed_valid,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int SHIFT   = GAIN_FRAC + FRACTION_BITS;
  localparam int SPD_LSH = (FRACTION_BITS > GAIN_FRAC) ? FRACTION_BITS - GAIN_FRAC : 0;
  localparam int SPD_RSH = (FRACTION_BITS < GAIN_FRAC) ? GAIN_FRAC - FRACTION_BITS : 0;
  localparam int NUMW    = SPD_PW + SPD_LSH;
  localparam int MAG_W   = 2 * MUL_A_W;
  localparam int IW      = MUL_P_W + MUL_A_W;
  localparam int HW      = TOTAL_W - SHIFT;

  state_t state, state_next;

  logic [22:0] speed_setpoint;
  logic [15:0] kp_gain, ki_gain, kd_gain, speed_scale;
  logic [9:0]  sample_period;
  logic [6:0]  drive_max;

  logic [31:0] last_count, last_time;
  logic        seeded;
  logic signed [SUM_WIDTH-1:0] error_sum;
  logic signed [SPEED_W-1:0]   last_error;

  logic [31:0] dt, dmag;
  logic        dneg, seed;
  logic signed [SPEED_W-1:0] speed_r, err_r;
  logic [SPEED_W-1:0] err_mag;
  logic [SPEED_W:0]   diff_mag;
  logic               diff_neg;
  logic [39:0]        pmag;
  logic [MUL_B_W-1:0] p_ki;
  logic [40:0]        dprod;
  logic [MUL_P_W-1:0] ilo;
  logic [IW-1:0]      iacc;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] prod;
  logic               div_start, div_done;
  logic [NUMW-1:0]    div_num, div_quot;
  logic [MUL_A_W-1:0] div_den;

  logic        accept, result_free, result_load;
  logic [31:0] dt_in, dc_in;

  logic [NUMW-1:0] num_spd, num_d;
  logic [9:0]      per;
  logic            q_big;
  logic [22:0]     q_low;
  logic signed [SPEED_W-1:0] speed_c, err_c;
  logic signed [SPEED_W:0]   err_w, diff_w;
  logic signed [SUM_WIDTH:0] sum_w;
  logic signed [SUM_WIDTH-1:0] sum_c;
  logic [SUM_WIDTH-1:0] esum_mag;
  logic [MAG_W-1:0]     m_ext;

  logic signed [7:0]         iterm, dterm;
  logic signed [8:0]         idsum;
  logic signed [TOTAL_W-1:0] pterm, total;
  logic [HW-1:0]             hi;
  logic [6:0]                drive_c;

  tsp_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  tsp_div #(.NW(NUMW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign accept      = item_valid && !item_stall;
  assign result_free = !result_valid || !result_stall;
  assign dt_in       = time_ms - last_time;
  assign dc_in       = tacho_count - last_count;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (accept) state_next = (!seeded || dt_in == '0) ? S_FIN : S_SPD_MUL;
      S_SPD_MUL: state_next = S_SPD_LD;
      S_SPD_LD:  state_next = S_SPD_DIV;
      S_SPD_DIV: if (div_done) state_next = S_ERR;
      S_ERR:     state_next = S_KP_MUL;
      S_KP_MUL:  state_next = S_KI_MUL;
      S_KI_MUL:  state_next = S_KD_MUL;
      S_KD_MUL:  state_next = S_SUM_LO;
      S_SUM_LO:  state_next = S_SUM_HI;
      S_SUM_HI:  state_next = S_D_LD;
      S_D_LD:    state_next = S_D_DIV;
      S_D_DIV:   if (div_done) state_next = S_FIN;
      S_FIN:     if (result_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    item_stall  = (state != S_IDLE);
    div_start   = (state == S_SPD_LD) || (state == S_D_LD);
    result_load = (state == S_FIN) && result_free;
  end

  always_comb begin
    per     = (sample_period == '0) ? 10'd1 : sample_period;
    num_spd = (NUMW'(prod[SPD_PW-1:0]) << SPD_LSH) >> SPD_RSH;
    num_d   = NUMW'(dprod >> SHIFT);
    div_num = (state == S_SPD_LD) ? num_spd : num_d;
    div_den = (state == S_SPD_LD) ? dt : MUL_A_W'(per);
  end

  always_comb begin
    esum_mag = error_sum[SUM_WIDTH-1] ? SUM_WIDTH'(-error_sum) : SUM_WIDTH'(error_sum);
    m_ext    = MAG_W'(esum_mag);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_SPD_MUL: begin
        mul_a = dmag;
        mul_b = MUL_B_W'(speed_scale);
      end
      S_KP_MUL: begin
        mul_a = MUL_A_W'(err_mag);
        mul_b = MUL_B_W'(kp_gain);
      end
      S_KI_MUL: begin
        mul_a = MUL_A_W'(ki_gain);
        mul_b = MUL_B_W'(sample_period);
      end
      S_KD_MUL: begin
        mul_a = MUL_A_W'(diff_mag);
        mul_b = MUL_B_W'(kd_gain);
      end
      S_SUM_LO: begin
        mul_a = m_ext[MUL_A_W-1:0];
        mul_b = p_ki;
      end
      S_SUM_HI: begin
        mul_a = m_ext[MAG_W-1:MUL_A_W];
        mul_b = p_ki;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    q_big = |div_quot[NUMW-1:SPEED_W-1];
    q_low = div_quot[SPEED_W-2:0];
    if (dneg) begin
      speed_c = q_big ? {1'b1, {(SPEED_W-1){1'b0}}} : -$signed({1'b0, q_low});
    end else begin
      speed_c = (q_big || (&q_low)) ? {1'b0, {(SPEED_W-1){1'b1}}} : $signed({1'b0, q_low});
    end
    err_w = $signed({2'b00, speed_setpoint}) - speed_c;
    if (err_w[SPEED_W] != err_w[SPEED_W-1]) begin
      err_c = err_w[SPEED_W] ? {1'b1, {(SPEED_W-1){1'b0}}} : {1'b0, {(SPEED_W-1){1'b1}}};
    end else begin
      err_c = err_w[SPEED_W-1:0];
    end
    diff_w = err_c - last_error;
    sum_w  = error_sum + err_c;
    if (sum_w[SUM_WIDTH] != sum_w[SUM_WIDTH-1]) begin
      sum_c = sum_w[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}} : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end else begin
      sum_c = sum_w[SUM_WIDTH-1:0];
    end
  end

  always_comb begin
    iterm = sat8(|iacc[IW-1:SHIFT+7], iacc[SHIFT+6:SHIFT], error_sum[SUM_WIDTH-1]);
    dterm = sat8(|div_quot[NUMW-1:7], div_quot[6:0], diff_neg);
    idsum = iterm + dterm;
    pterm = err_r[SPEED_W-1] ? -$signed({2'b00, pmag}) : $signed({2'b00, pmag});
    total = pterm + (TOTAL_W'(idsum) <<< SHIFT);
    hi    = total[TOTAL_W-1:SHIFT];
    if (total[TOTAL_W-1]) begin
      drive_c = '0;
    end else if ((|hi[HW-1:7]) || (hi[6:0] > drive_max)) begin
      drive_c = drive_max;
    end else begin
      drive_c = hi[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      speed_setpoint <= TARGET_RST;
      kp_gain        <= KP_RST;
      ki_gain        <= KI_RST;
      kd_gain        <= KD_RST;
      speed_scale    <= SCALE_RST;
      sample_period  <= PERIOD_RST;
      drive_max      <= DRIVE_MAX_RST;
      last_count     <= '0;
      last_time      <= '0;
      seeded         <= 1'b0;
      error_sum      <= '0;
      last_error     <= '0;
      result_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_TARGET:    speed_setpoint <= cfg_data[22:0];
          REG_KP:        kp_gain        <= cfg_data[15:0];
          REG_KI:        ki_gain        <= cfg_data[15:0];
          REG_KD:        kd_gain        <= cfg_data[15:0];
          REG_SCALE:     speed_scale    <= cfg_data[15:0];
          REG_PERIOD:    sample_period  <= cfg_data[9:0];
          REG_DRIVE_MAX: drive_max      <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (accept) begin
        last_count <= tacho_count;
        last_time  <= time_ms;
        seeded     <= 1'b1;
      end
      if (state == S_ERR) begin
        error_sum  <= sum_c;
        last_error <= err_c;
      end
      if (result_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dt   <= dt_in;
      dneg <= dc_in[31];
      dmag <= dc_in[31] ? -dc_in : dc_in;
      seed <= !seeded || dt_in == '0;
    end
    unique case (state)
      S_ERR: begin
        speed_r  <= speed_c;
        err_r    <= err_c;
        err_mag  <= err_c[SPEED_W-1] ? SPEED_W'(-err_c) : SPEED_W'(err_c);
        diff_neg <= diff_w[SPEED_W];
        diff_mag <= diff_w[SPEED_W] ? (SPEED_W+1)'(-diff_w) : (SPEED_W+1)'(diff_w);
      end
      S_KI_MUL: pmag  <= prod[39:0];
      S_KD_MUL: p_ki  <= prod[MUL_B_W-1:0];
      S_SUM_LO: dprod <= prod[40:0];
      S_SUM_HI: ilo   <= prod;
      S_D_LD:   iacc  <= (IW'(prod) << MUL_A_W) + IW'(ilo);
      default: ;
    endcase
    if (result_load) begin
      drive_level    <= seed ? '0 : drive_c;
      measured_speed <= seed ? '0 : speed_r;
      speed_error    <= seed ? '0 : err_r;
      speed_valid    <= !seed;
    end
  end

  a_drive_clamped: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> drive_level <= drive_max)
    else $error("motor drive above clamp");

  a_seed_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !speed_valid |->
      (drive_level == '0 && measured_speed == '0 && speed_error == '0))
    else $error("seed result not zero");

  a_dt_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_SPD_DIV |-> dt != '0)
    else $error("speed division with zero time delta");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_FIN)
    else $error("result raised outside final step");

endmodule

// ===== verif/pid_drive_checker.sv =====
// Checker for the tacho speed PID drive unit: watches the config port and the request and result
// channels, predicts each drive result and compares it field by field with what comes out.
// Depends on tsp_pkg for widths and register indexes.
module pid_drive_checker import tsp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  input  logic                     item_stall,
  input  logic [31:0]              tacho_count,
  input  logic [31:0]              time_ms,
  input  logic                     result_valid,
  input  logic                     result_stall,
  input  logic [6:0]               drive_level,
  input  logic signed [SPEED_W-1:0] measured_speed,
  input  logic signed [SPEED_W-1:0] speed_error,
  input  logic                     speed_valid,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  output int                       mismatches,
  output int                       outstanding,
  output int                       checked
);

  localparam int     TERM_SHIFT = GAIN_FRAC + FRACTION_BITS_DEF;
  localparam longint SPEED_MAX  = 64'sd8388607;
  localparam longint SPEED_MIN  = -64'sd8388608;
  localparam longint SUM_MAX    = (64'sd1 <<< (SUM_WIDTH_DEF - 1)) - 64'sd1;
  localparam longint SUM_MIN    = -SUM_MAX - 64'sd1;

  typedef struct packed {
    logic [6:0]               drive;
    logic signed [SPEED_W-1:0] speed;
    logic signed [SPEED_W-1:0] err;
    logic                     valid;
  } drive_result_t;

  drive_result_t due_drives[$];

  logic [22:0] target;
  logic [15:0] kp, ki, kd, scale;
  logic [9:0]  period;
  logic [6:0]  dmax;

  logic [31:0] prev_count, prev_time;
  longint      err_sum, prev_err;
  bit          primed;

  function automatic longint clamp_speed(input longint v);
    if (v > SPEED_MAX) return SPEED_MAX;
    if (v < SPEED_MIN) return SPEED_MIN;
    return v;
  endfunction

  function automatic longint clip_term(input logic [127:0] mag, input bit neg);
    longint low;
    low = longint'({56'd0, mag[7:0]});
    if (neg) return (mag >= 128) ? -64'sd128 : -low;
    return (mag >= 127) ? 64'sd127 : low;
  endfunction

  function automatic drive_result_t predict_drive(input logic [31:0] count,
                                                  input logic [31:0] now);
    drive_result_t r;
    logic [31:0]   dt, dc, dmag;
    logic [63:0]   num, quot, kprod, smag, dprod, per;
    logic [127:0]  iprod;
    longint        speed, err, diff, iterm, dterm, total, drv, cap;
    bit            dneg;
    r = '0;
    dt = now - prev_time;
    dc = count - prev_count;
    if (!primed || dt == 32'd0) begin
      prev_count = count;
      prev_time = now;
      primed = 1'b1;
      return r;
    end
    prev_count = count;
    prev_time = now;

    dneg = dc[31];
    dmag = dneg ? 32'd0 - dc : dc;
    num = ({32'd0, dmag} * {48'd0, scale}) << FRACTION_BITS_DEF;
    quot = num / ({32'd0, dt} << GAIN_FRAC);
    if (dneg) speed = (quot >= 64'd8388608) ? SPEED_MIN : -longint'(quot);
    else      speed = (quot >= 64'd8388607) ? SPEED_MAX : longint'(quot);

    err = clamp_speed(longint'({41'd0, target}) - speed);

    if (err > 0 && err_sum > SUM_MAX - err)      err_sum = SUM_MAX;
    else if (err < 0 && err_sum < SUM_MIN - err) err_sum = SUM_MIN;
    else                                         err_sum = err_sum + err;

    kprod = {48'd0, ki} * {54'd0, period};
    smag = (err_sum < 0) ? -err_sum : err_sum;
    iprod = {64'd0, smag} * {64'd0, kprod};
    iterm = clip_term(iprod >> TERM_SHIFT, err_sum < 0);

    diff = err - prev_err;
    dprod = (diff < 0) ? -diff : diff;
    dprod = dprod * {48'd0, kd};
    per = {54'd0, period};
    if (per == 64'd0) per = 64'd1;
    quot = dprod / (per << TERM_SHIFT);
    dterm = clip_term({64'd0, quot}, diff < 0);
    prev_err = err;

    total = longint'({48'd0, kp}) * err + (iterm + dterm) * (64'sd1 <<< TERM_SHIFT);
    drv = 0;
    cap = longint'({57'd0, dmax});
    if (total > 0) begin
      drv = total >>> TERM_SHIFT;
      if (drv > cap) drv = cap;
    end

    r.drive = drv[6:0];
    r.speed = speed[SPEED_W-1:0];
    r.err = err[SPEED_W-1:0];
    r.valid = 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin
    drive_result_t want;
    if (rst) begin
      target = TARGET_RST;
      kp = KP_RST;
      ki = KI_RST;
      kd = KD_RST;
      scale = SCALE_RST;
      period = PERIOD_RST;
      dmax = DRIVE_MAX_RST;
      prev_count = '0;
      prev_time = '0;
      err_sum = 0;
      prev_err = 0;
      primed = 1'b0;
      due_drives.delete();
      mismatches = 0;
      outstanding = 0;
      checked = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_TARGET:    target = cfg_data[22:0];
          REG_KP:        kp = cfg_data[15:0];
          REG_KI:        ki = cfg_data[15:0];
          REG_KD:        kd = cfg_data[15:0];
          REG_SCALE:     scale = cfg_data[15:0];
          REG_PERIOD:    period = cfg_data[9:0];
          REG_DRIVE_MAX: dmax = cfg_data[6:0];
          default: ;
        endcase
      end
      if (item_valid && !item_stall) due_drives.push_back(predict_drive(tacho_count, time_ms));
      if (result_valid && !result_stall) begin
        if (due_drives.size() == 0) begin
          $error("drive result with no request pending");
          mismatches++;
        end else begin
          want = due_drives.pop_front();
          checked++;
          if (drive_level !== want.drive) begin
            $error("drive_level expected %0d got %0d", want.drive, drive_level);
            mismatches++;
          end
          if (measured_speed !== want.speed) begin
            $error("measured_speed expected %0d got %0d", want.speed, measured_speed);
            mismatches++;
          end
          if (speed_error !== want.err) begin
            $error("speed_error expected %0d got %0d", want.err, speed_error);
            mismatches++;
          end
          if (speed_valid !== want.valid) begin
            $error("speed_valid expected %0d got %0d", want.valid, speed_valid);
            mismatches++;
          end
        end
      end
      outstanding = due_drives.size();
    end
  end

endmodule

// ===== verif/tacho_speed_pid_drive_unit_test.sv =====
// Top of the tacho speed PID drive unit testbench: clock, reset, register settings and
// tacho requests with random idle bursts and one long output hold; verdict from the checker.
// Depends on tsp_pkg, tacho_speed_pid_drive_unit and pid_drive_checker.
module tacho_speed_pid_drive_unit_test import tsp_pkg::*; ();

  localparam int REQUESTS     = 900;
  localparam int PHASES       = 8;
  localparam int HOLD_CYCLES  = 700;
  localparam int DRAIN_CYCLES = 150;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                      clk;
  logic                      rst;
  logic                      item_valid;
  logic                      item_stall;
  logic [31:0]               tacho_count;
  logic [31:0]               time_ms;
  logic                      result_valid;
  logic                      result_stall;
  logic [6:0]                drive_level;
  logic signed [SPEED_W-1:0] measured_speed;
  logic signed [SPEED_W-1:0] speed_error;
  logic                      speed_valid;
  logic                      cfg_write;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;

  logic [CFG_DATA_W-1:0] cfg_plan [8];
  logic [31:0]           cur_count, cur_time;
  bit                    bursts_on, long_hold, hold_done;
  int                    sent, cycles, phase, roll;
  int                    mismatches, outstanding, checked;

  tacho_speed_pid_drive_unit dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .tacho_count(tacho_count),
    .time_ms(time_ms),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .drive_level(drive_level),
    .measured_speed(measured_speed),
    .speed_error(speed_error),
    .speed_valid(speed_valid),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  pid_drive_checker chk (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .tacho_count(tacho_count),
    .time_ms(time_ms),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .drive_level(drive_level),
    .measured_speed(measured_speed),
    .speed_error(speed_error),
    .speed_valid(speed_valid),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatches(mismatches),
    .outstanding(outstanding),
    .checked(checked)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    result_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold && !hold_done) begin
        hold_done = 1'b1;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        result_stall <= 1'b0;
      end else if (bursts_on && $urandom_range(0, 3) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  task automatic send_request(input logic [31:0] count, input logic [31:0] stamp);
    @(negedge clk);
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    item_valid <= 1'b1;
    tacho_count <= count;
    time_ms <= stamp;
    do @(posedge clk); while (item_stall);
    sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    item_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apply_settings();
    settle();
    for (int i = 0; i <= REG_UNUSED; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= cfg_plan[i];
      @(negedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  task automatic plan_settings(input int k);
    case (k)
      0: foreach (cfg_plan[i]) cfg_plan[i] = '1;
      1: foreach (cfg_plan[i]) cfg_plan[i] = '0;
      default: begin
        if ($urandom_range(0, 3) == 0) cfg_plan[REG_TARGET] = 23'($urandom);
        else cfg_plan[REG_TARGET] = 23'($urandom_range(0, 20000));
        if (k % 2 == 0) begin
          cfg_plan[REG_KP] = {7'($urandom), 16'($urandom_range(0, 4095))};
          cfg_plan[REG_KI] = {7'($urandom), 16'($urandom_range(0, 4095))};
          cfg_plan[REG_KD] = {7'($urandom), 16'($urandom_range(0, 4095))};
        end else begin
          cfg_plan[REG_KP] = 23'($urandom);
          cfg_plan[REG_KI] = 23'($urandom);
          cfg_plan[REG_KD] = 23'($urandom);
        end
        cfg_plan[REG_SCALE] = {7'($urandom), 16'($urandom_range(1, 65535))};
        if (k == 2) cfg_plan[REG_PERIOD] = {13'($urandom), 10'd0};
        else cfg_plan[REG_PERIOD] = {13'($urandom), 10'($urandom_range(1, 1023))};
        cfg_plan[REG_DRIVE_MAX] = {16'($urandom), 7'($urandom_range(0, 127))};
        cfg_plan[REG_UNUSED] = 23'($urandom);
      end
    endcase
  endtask

  initial begin
    bursts_on = 1'b1;
    long_hold = 1'b0;
    sent = 0;
    item_valid = 1'b0;
    tacho_count = '0;
    time_ms = '0;
    cfg_write = 1'b0;
    cfg_index = REG_TARGET;
    cfg_data = '0;
    rst = 1'b1;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'h0000_0004, 32'h0000_0031);
    send_request(32'h0000_0009, 32'h0000_0031);
    send_request(32'h0000_0004, 32'h0000_0063);
    send_request(32'h0000_0004, 32'h0000_0095);
    send_request(32'h8000_0003, 32'h0000_0096);
    send_request(32'h0000_0003, 32'h0000_0097);
    send_request(32'h0000_0004, 32'h0000_0096);
    send_request(32'h0000_0000, 32'h0000_0000);
    cur_count = 32'h0000_0100;
    cur_time = 32'h0000_0200;
    for (int n = 0; n < 8; n++) begin
      cur_count = cur_count + 32'd7;
      cur_time = cur_time + 32'd50;
      send_request(cur_count, cur_time);
    end

    for (phase = 0; phase < PHASES; phase++) begin
      plan_settings(phase);
      apply_settings();
      if (phase == PHASES - 1) bursts_on = 1'b0;
      for (int n = 0; n < REQUESTS / PHASES; n++) begin
        if (phase == 2 && n == 10) long_hold = 1'b1;
        roll = $urandom_range(0, 99);
        if (roll < 72) begin
          cur_time = cur_time + 32'($urandom_range(1, 120));
          cur_count = cur_count + 32'($urandom_range(0, 80)) - 32'd16;
        end else if (roll < 80) begin
          cur_time = cur_time + 32'($urandom_range(1, 65535));
          cur_count = cur_count + 32'($urandom);
        end else if (roll < 86) begin
          cur_count = cur_count + 32'($urandom_range(0, 9));
        end else begin
          cur_time = 32'($urandom);
          cur_count = 32'($urandom);
        end
        send_request(cur_count, cur_time);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Drove %0d tacho requests through %0d register settings, zero period included.",
             sent, PHASES + 1);
    $display("Compared %0d drive results; output was held once for %0d cycles.",
             checked, HOLD_CYCLES);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
